// ===== rtl/atum_pkg.sv =====
// shared types and constants of the alpha tree union merge block
`default_nettype none

package atum_pkg;

   // fixed field widths of the item channels
   localparam int CMD_W    = 2;
   localparam int NP_W     = 11;
   localparam int NQ_W     = 10;
   localparam int EA_W     = 16;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 11;
   localparam int AREA_W   = 11;
   localparam int PC_W     = 11;

   localparam logic [PC_W-1:0] PIXEL_COUNT_RESET = 11'd1024;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INIT_DONE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SAME_ROOT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NEW_NODE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_DATA = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   // datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE          = 5'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT        = 5'd1;
   localparam logic [OP_W-1:0] OP_INIT_STEP     = 5'd2;
   localparam logic [OP_W-1:0] OP_INIT_END      = 5'd3;
   localparam logic [OP_W-1:0] OP_FIND_BEGIN    = 5'd4;
   localparam logic [OP_W-1:0] OP_FIND_READ     = 5'd5;
   localparam logic [OP_W-1:0] OP_FIND_STEP     = 5'd6;
   localparam logic [OP_W-1:0] OP_COMP_READ     = 5'd7;
   localparam logic [OP_W-1:0] OP_COMP_WRITE    = 5'd8;
   localparam logic [OP_W-1:0] OP_ROOT_SAVE     = 5'd9;
   localparam logic [OP_W-1:0] OP_ORDER         = 5'd10;
   localparam logic [OP_W-1:0] OP_READ_HI       = 5'd11;
   localparam logic [OP_W-1:0] OP_READ_LO       = 5'd12;
   localparam logic [OP_W-1:0] OP_LATCH_LO      = 5'd13;
   localparam logic [OP_W-1:0] OP_JOIN_HI       = 5'd14;
   localparam logic [OP_W-1:0] OP_JOIN_LO       = 5'd15;
   localparam logic [OP_W-1:0] OP_NEW_NODE      = 5'd16;
   localparam logic [OP_W-1:0] OP_MERGE_LO      = 5'd17;
   localparam logic [OP_W-1:0] OP_MERGE_HI      = 5'd18;
   localparam logic [OP_W-1:0] OP_RES_SAME      = 5'd19;
   localparam logic [OP_W-1:0] OP_RES_FULL      = 5'd20;
   localparam logic [OP_W-1:0] OP_READ_NODE     = 5'd21;
   localparam logic [OP_W-1:0] OP_RES_READ      = 5'd22;
   localparam logic [OP_W-1:0] OP_RES_READ_NONE = 5'd23;
   localparam logic [OP_W-1:0] OP_PUBLISH       = 5'd24;

   typedef struct packed {
      logic range_bad;
      logic read_bad;
      logic link_follow;
      logic y_is_root;
      logic second;
      logic roots_equal;
      logic below;
      logic full;
      logic sweep_last;
   } atum_status_type;

endpackage

`default_nettype wire

// ===== rtl/atum_dpath.sv =====
// node memory, find registers and result registers
`default_nettype none

module atum_dpath #(
   parameter int MAX_PIXELS = 1024,
   parameter int ALPHA_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [atum_pkg::OP_W-1:0]     op,
   input  logic [atum_pkg::NP_W-1:0]     req_node_p,
   input  logic [atum_pkg::NQ_W-1:0]     req_node_q,
   input  logic [atum_pkg::EA_W-1:0]     req_edge_alpha,
   input  logic [atum_pkg::PC_W-1:0]     pixel_count,
   output atum_pkg::atum_status_type     status,
   output logic [atum_pkg::STATUS_W-1:0] rsp_status,
   output logic [atum_pkg::IDX_W-1:0]    rsp_new_node,
   output logic                          rsp_node_has_parent,
   output logic [atum_pkg::IDX_W-1:0]    rsp_node_parent,
   output logic                          rsp_node_is_leaf_alpha,
   output logic [atum_pkg::EA_W-1:0]     rsp_node_alpha,
   output logic [atum_pkg::AREA_W-1:0]   rsp_node_area,
   output logic [atum_pkg::IDX_W-1:0]    rsp_node_count
);
   import atum_pkg::*;

   localparam int DEPTH = 2 * MAX_PIXELS - 1;
   localparam int NW    = $clog2(DEPTH);
   localparam int AB    = ALPHA_BITS;
   localparam int ARW   = $clog2(MAX_PIXELS + 1);
   localparam int EW    = (NW > NP_W) ? NW : NP_W;
   localparam int AL_LO = ARW;
   localparam int LV_LO = ARW + AB + 1;
   localparam int LK_LO = LV_LO + 2;
   localparam int PA_LO = LK_LO + NW;
   localparam int WW    = PA_LO + NW;

   logic [WW-1:0] node_mem [DEPTH];

   logic [NP_W-1:0]     np_ff;
   logic [NQ_W-1:0]     nq_ff;
   logic [AB-1:0]       ea_ff;
   logic [NW-1:0]       n_ff, sweep_ff, used_ff;
   logic [NW-1:0]       r_ff, y_ff, r1_ff, hi_ff, lo_ff;
   logic                second_ff;
   logic [WW-1:0]       rdata_ff, hi_word_ff, lo_word_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]    res_new_node_ff, res_parent_ff;
   logic                res_has_parent_ff, res_leaf_ff;
   logic [EA_W-1:0]     res_alpha_ff;
   logic [AREA_W-1:0]   res_area_ff;

   logic          rd_en, wr_en;
   logic [NW-1:0] rd_addr, wr_addr;
   logic [WW-1:0] wr_data;

   logic [EW-1:0] np_ext, nq_ext, used_ext;
   logic [31:0]   pc32, n32;

   logic [ARW-1:0] rd_area, hi_area, lo_area, area_sum;
   logic [AB:0]    rd_alpha, hi_alpha, lo_alpha;
   logic [1:0]     rd_lv, hi_lv;
   logic [NW-1:0]  rd_link, rd_parent, hi_link, hi_parent;

   assign rd_area   = rdata_ff[AL_LO-1:0];
   assign rd_alpha  = rdata_ff[LV_LO-1:AL_LO];
   assign rd_lv     = rdata_ff[LK_LO-1:LV_LO];
   assign rd_link   = rdata_ff[PA_LO-1:LK_LO];
   assign rd_parent = rdata_ff[WW-1:PA_LO];
   assign hi_area   = hi_word_ff[AL_LO-1:0];
   assign hi_alpha  = hi_word_ff[LV_LO-1:AL_LO];
   assign hi_lv     = hi_word_ff[LK_LO-1:LV_LO];
   assign hi_link   = hi_word_ff[PA_LO-1:LK_LO];
   assign hi_parent = hi_word_ff[WW-1:PA_LO];
   assign lo_area   = lo_word_ff[AL_LO-1:0];
   assign lo_alpha  = lo_word_ff[LV_LO-1:AL_LO];
   assign area_sum  = hi_area + lo_area;

   assign np_ext   = EW'(np_ff);
   assign nq_ext   = EW'(nq_ff);
   assign used_ext = EW'(used_ff);

   // clamp pixel count to 1..MAX_PIXELS
   assign pc32 = 32'(pixel_count);
   assign n32  = (pc32 == 32'd0) ? 32'd1 :
                 (pc32 > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : pc32;

   assign status.range_bad   = (np_ext >= used_ext) || (nq_ext >= used_ext);
   assign status.read_bad    = (np_ext >= used_ext);
   assign status.link_follow = rd_lv[0] && (rd_link < NW'(DEPTH));
   assign status.y_is_root   = (y_ff == r_ff);
   assign status.second      = second_ff;
   assign status.roots_equal = (r1_ff == r_ff);
   assign status.below       = hi_alpha[AB] || (hi_alpha[AB-1:0] < ea_ff);
   assign status.full        = (used_ff >= NW'(DEPTH));
   assign status.sweep_last  = (sweep_ff == n_ff - NW'(1));

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (op)
         OP_INIT_STEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = {{NW{1'b0}}, {NW{1'b0}}, 2'b00, {1'b1, {AB{1'b0}}}, ARW'(1)};
         end
         OP_FIND_READ: begin
            rd_en   = 1'b1;
            rd_addr = r_ff;
         end
         OP_COMP_READ: begin
            rd_en   = 1'b1;
            rd_addr = y_ff;
         end
         OP_COMP_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = y_ff;
            wr_data = {rd_parent, r_ff, rd_lv, rd_alpha, rd_area};
         end
         OP_READ_HI: begin
            rd_en   = 1'b1;
            rd_addr = hi_ff;
         end
         OP_READ_LO: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff;
         end
         OP_JOIN_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = {used_ff, used_ff, 2'b11, hi_alpha, hi_area};
         end
         OP_JOIN_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = {used_ff, used_ff, 2'b11, lo_alpha, lo_area};
         end
         OP_NEW_NODE: begin
            wr_en   = 1'b1;
            wr_addr = used_ff;
            wr_data = {{NW{1'b0}}, {NW{1'b0}}, 2'b00, {1'b0, ea_ff}, area_sum};
         end
         OP_MERGE_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = {hi_ff, hi_ff, 2'b11, lo_alpha, lo_area};
         end
         OP_MERGE_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = {hi_parent, hi_link, hi_lv, hi_alpha, area_sum};
         end
         OP_READ_NODE: begin
            rd_en   = 1'b1;
            rd_addr = np_ext[NW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= node_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         second_ff <= 1'b0;
      end else begin
         unique case (op)
            OP_ACCEPT: begin
               np_ff             <= req_node_p;
               nq_ff             <= req_node_q;
               ea_ff             <= AB'(req_edge_alpha);
               n_ff              <= NW'(n32);
               sweep_ff          <= '0;
               second_ff         <= 1'b0;
               res_status_ff     <= ST_INIT_DONE;
               res_new_node_ff   <= '0;
               res_has_parent_ff <= 1'b0;
               res_parent_ff     <= '0;
               res_leaf_ff       <= 1'b0;
               res_alpha_ff      <= '0;
               res_area_ff       <= '0;
            end
            OP_INIT_STEP: sweep_ff <= sweep_ff + NW'(1);
            OP_INIT_END: begin
               used_ff       <= n_ff;
               res_status_ff <= ST_INIT_DONE;
            end
            OP_FIND_BEGIN: begin
               r_ff <= second_ff ? nq_ext[NW-1:0] : np_ext[NW-1:0];
               y_ff <= second_ff ? nq_ext[NW-1:0] : np_ext[NW-1:0];
            end
            OP_FIND_STEP:  r_ff <= rd_link;
            OP_COMP_WRITE: y_ff <= rd_link;
            OP_ROOT_SAVE: begin
               r1_ff     <= r_ff;
               second_ff <= 1'b1;
            end
            OP_ORDER: begin
               hi_ff <= (r1_ff > r_ff) ? r1_ff : r_ff;
               lo_ff <= (r1_ff > r_ff) ? r_ff : r1_ff;
            end
            OP_READ_LO:  hi_word_ff <= rdata_ff;
            OP_LATCH_LO: lo_word_ff <= rdata_ff;
            OP_NEW_NODE: begin
               used_ff         <= used_ff + NW'(1);
               res_status_ff   <= ST_NEW_NODE;
               res_new_node_ff <= IDX_W'(used_ff);
            end
            OP_MERGE_HI:      res_status_ff <= ST_MERGED;
            OP_RES_SAME:      res_status_ff <= ST_SAME_ROOT;
            OP_RES_FULL:      res_status_ff <= ST_FULL;
            OP_RES_READ_NONE: res_status_ff <= ST_READ_DATA;
            OP_RES_READ: begin
               res_status_ff     <= ST_READ_DATA;
               res_has_parent_ff <= rd_lv[1];
               res_parent_ff     <= rd_lv[1] ? IDX_W'(rd_parent) : '0;
               res_leaf_ff       <= rd_alpha[AB];
               res_alpha_ff      <= rd_alpha[AB] ? '0 : EA_W'(rd_alpha[AB-1:0]);
               res_area_ff       <= AREA_W'(rd_area);
            end
            OP_PUBLISH: begin
               rsp_status             <= res_status_ff;
               rsp_new_node           <= res_new_node_ff;
               rsp_node_has_parent    <= res_has_parent_ff;
               rsp_node_parent        <= res_parent_ff;
               rsp_node_is_leaf_alpha <= res_leaf_ff;
               rsp_node_alpha         <= res_alpha_ff;
               rsp_node_area          <= res_area_ff;
               rsp_node_count         <= IDX_W'(used_ff);
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atum_ctrl.sv =====
// command sequencer for init sweep, root finding, merge and read
`default_nettype none

module atum_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [atum_pkg::CMD_W-1:0] req_cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  atum_pkg::atum_status_type  status,
   output logic [atum_pkg::OP_W-1:0]  op
);
   import atum_pkg::*;

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_INIT       = 5'd1;
   localparam logic [4:0] S_INIT_END   = 5'd2;
   localparam logic [4:0] S_CHECK      = 5'd3;
   localparam logic [4:0] S_FIND_BEGIN = 5'd4;
   localparam logic [4:0] S_FIND_READ  = 5'd5;
   localparam logic [4:0] S_FIND_EVAL  = 5'd6;
   localparam logic [4:0] S_COMP_CHECK = 5'd7;
   localparam logic [4:0] S_COMP_WRITE = 5'd8;
   localparam logic [4:0] S_ROOT_SAVE  = 5'd9;
   localparam logic [4:0] S_ORDER      = 5'd10;
   localparam logic [4:0] S_READ_HI    = 5'd11;
   localparam logic [4:0] S_READ_LO    = 5'd12;
   localparam logic [4:0] S_DECIDE     = 5'd13;
   localparam logic [4:0] S_JOIN_HI    = 5'd14;
   localparam logic [4:0] S_JOIN_LO    = 5'd15;
   localparam logic [4:0] S_NEW_NODE   = 5'd16;
   localparam logic [4:0] S_MERGE_LO   = 5'd17;
   localparam logic [4:0] S_MERGE_HI   = 5'd18;
   localparam logic [4:0] S_READ_NODE  = 5'd19;
   localparam logic [4:0] S_READ_OUT   = 5'd20;
   localparam logic [4:0] S_FINISH     = 5'd21;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       publish;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign publish   = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = publish || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = OP_ACCEPT;
               if (req_cmd == CMD_INIT) begin
                  state_in = S_INIT;
               end else if (req_cmd == CMD_EDGE) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_READ_NODE;
               end
            end
         end
         S_INIT: begin
            op = OP_INIT_STEP;
            if (status.sweep_last) begin
               state_in = S_INIT_END;
            end
         end
         S_INIT_END: begin
            op       = OP_INIT_END;
            state_in = S_FINISH;
         end
         S_CHECK: begin
            if (status.range_bad) begin
               op       = OP_RES_SAME;
               state_in = S_FINISH;
            end else begin
               state_in = S_FIND_BEGIN;
            end
         end
         S_FIND_BEGIN: begin
            op       = OP_FIND_BEGIN;
            state_in = S_FIND_READ;
         end
         S_FIND_READ: begin
            op       = OP_FIND_READ;
            state_in = S_FIND_EVAL;
         end
         S_FIND_EVAL: begin
            if (status.link_follow) begin
               op       = OP_FIND_STEP;
               state_in = S_FIND_READ;
            end else begin
               state_in = S_COMP_CHECK;
            end
         end
         S_COMP_CHECK: begin
            if (status.y_is_root) begin
               state_in = S_ROOT_SAVE;
            end else begin
               op       = OP_COMP_READ;
               state_in = S_COMP_WRITE;
            end
         end
         S_COMP_WRITE: begin
            op       = OP_COMP_WRITE;
            state_in = S_COMP_CHECK;
         end
         S_ROOT_SAVE: begin
            if (status.second) begin
               state_in = S_ORDER;
            end else begin
               op       = OP_ROOT_SAVE;
               state_in = S_FIND_BEGIN;
            end
         end
         S_ORDER: begin
            if (status.roots_equal) begin
               op       = OP_RES_SAME;
               state_in = S_FINISH;
            end else begin
               op       = OP_ORDER;
               state_in = S_READ_HI;
            end
         end
         S_READ_HI: begin
            op       = OP_READ_HI;
            state_in = S_READ_LO;
         end
         S_READ_LO: begin
            op       = OP_READ_LO;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.below && status.full) begin
               op       = OP_RES_FULL;
               state_in = S_FINISH;
            end else begin
               op       = OP_LATCH_LO;
               state_in = status.below ? S_JOIN_HI : S_MERGE_LO;
            end
         end
         S_JOIN_HI: begin
            op       = OP_JOIN_HI;
            state_in = S_JOIN_LO;
         end
         S_JOIN_LO: begin
            op       = OP_JOIN_LO;
            state_in = S_NEW_NODE;
         end
         S_NEW_NODE: begin
            op       = OP_NEW_NODE;
            state_in = S_FINISH;
         end
         S_MERGE_LO: begin
            op       = OP_MERGE_LO;
            state_in = S_MERGE_HI;
         end
         S_MERGE_HI: begin
            op       = OP_MERGE_HI;
            state_in = S_FINISH;
         end
         S_READ_NODE: begin
            if (status.read_bad) begin
               op       = OP_RES_READ_NONE;
               state_in = S_FINISH;
            end else begin
               op       = OP_READ_NODE;
               state_in = S_READ_OUT;
            end
         end
         S_READ_OUT: begin
            op       = OP_RES_READ;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (publish) begin
               op       = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/alpha_tree_union_merge.sv =====
// alpha tree union merge: top level with register port, sequencer and datapath
//
// usage: items enter on the req_ channel (valid/stall), one result item per
// input item leaves on the rsp_ channel (valid/stall). an item is taken only
// while the sequencer is idle; req_stall is high while one item is at work.
// init (cmd 0) sweeps the node memory one leaf per cycle. a read (cmd 2 or 3)
// returns one node, or empty fields when the node is not in the tree. an edge
// (cmd 1) walks and compresses both root chains through the single-port node
// memory and ends in same root, a full store, a merge or a new node; an index
// out of range reports same root without touching the node memory.
// pixel_count is written through the apb-style csr port (byte address 0) and
// takes effect at the next init; write it only while the block is idle.
// reset clears the sequencer and the node count: the tree is empty and every
// edge reports same root until an init. a stalled result waits in the output
// register; the next item may be taken and worked on meanwhile, and its result
// is held back until the output register is free.
`default_nettype none

module alpha_tree_union_merge #(
   parameter int MAX_PIXELS = 1024,
   parameter int ALPHA_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input item channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [atum_pkg::CMD_W-1:0]    req_cmd,
   input  logic [atum_pkg::NP_W-1:0]     req_node_p,
   input  logic [atum_pkg::NQ_W-1:0]     req_node_q,
   input  logic [atum_pkg::EA_W-1:0]     req_edge_alpha,
   // result item channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [atum_pkg::STATUS_W-1:0] rsp_status,
   output logic [atum_pkg::IDX_W-1:0]    rsp_new_node,
   output logic                          rsp_node_has_parent,
   output logic [atum_pkg::IDX_W-1:0]    rsp_node_parent,
   output logic                          rsp_node_is_leaf_alpha,
   output logic [atum_pkg::EA_W-1:0]     rsp_node_alpha,
   output logic [atum_pkg::AREA_W-1:0]   rsp_node_area,
   output logic [atum_pkg::IDX_W-1:0]    rsp_node_count,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import atum_pkg::*;

   logic [PC_W-1:0] pixel_count_ff, pixel_count_in;
   logic            csr_write;
   logic [OP_W-1:0] op;
   atum_status_type status;

   // only register 0 exists; paddr[2] set selects nothing
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign pixel_count_in = csr_write ? pwdata[PC_W-1:0] : pixel_count_ff;
   assign prdata    = (paddr[2] == 1'b0) ? 32'(pixel_count_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else begin
         pixel_count_ff <= pixel_count_in;
      end
   end

   // sequencer: at most one memory access per state
   atum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .op        (op)
   );

   // node memory, root registers and output register
   atum_dpath #(
      .MAX_PIXELS (MAX_PIXELS),
      .ALPHA_BITS (ALPHA_BITS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .op                     (op),
      .req_node_p             (req_node_p),
      .req_node_q             (req_node_q),
      .req_edge_alpha         (req_edge_alpha),
      .pixel_count            (pixel_count_ff),
      .status                 (status),
      .rsp_status             (rsp_status),
      .rsp_new_node           (rsp_new_node),
      .rsp_node_has_parent    (rsp_node_has_parent),
      .rsp_node_parent        (rsp_node_parent),
      .rsp_node_is_leaf_alpha (rsp_node_is_leaf_alpha),
      .rsp_node_alpha         (rsp_node_alpha),
      .rsp_node_area          (rsp_node_area),
      .rsp_node_count         (rsp_node_count)
   );

endmodule

`default_nettype wire
